@@ rtl/core/rgbhsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// shared widths and payload types of the rgb to hsl pixel core
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

    localparam int CHAN_W      = 8;
    localparam int CHAN_MAX    = 255;
    localparam int SUM_TOP     = 510;

    // hue: 255 * d over 6 * range, d up to 1785
    localparam int HUE_NUM_W   = 19;
    localparam int HUE_DEN_W   = 11;
    // saturation: 255 * range over min(sum, 510 - sum)
    localparam int SAT_NUM_W   = 16;
    localparam int SAT_DEN_W   = 9;

    // quotient bits, one divider stage per bit
    localparam int QUO_W       = 9;
    localparam int HUE_CW      = HUE_DEN_W + QUO_W;
    localparam int SAT_CW      = SAT_DEN_W + QUO_W;

    localparam int PREP_STAGES = 2;
    localparam int PIPE_DEPTH  = PREP_STAGES + QUO_W + 1;

    typedef struct packed {
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DEN_W-1:0] sat_den;
        logic                 gray;
        logic [CHAN_W-1:0]    light;
    } prep_t;

    typedef struct packed {
        logic [QUO_W-1:0]  hue_q;
        logic [QUO_W-1:0]  sat_q;
        logic              gray;
        logic [CHAN_W-1:0] light;
    } quot_t;

endpackage

@@ rtl/core/rgb_to_hsl_pixel_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl_pixel_core
// 8-bit rgb pixel to 8-bit hue, saturation and lightness, one pixel per clock
// ----------------------------------------------------------------------------
//
//   channel   | direction | tdata (lsb first)              | tlast/tuser
//   ----------+-----------+--------------------------------+------------
//   s_axis    | in        | blue, green, red (8 bits each) | none
//   m_axis    | out       | hue, saturation, lightness     | none
//
// one transfer in per clock when the output side keeps up; the pipe holds
// two operand stages, nine divider stages (one quotient bit each, set by
// the 9-bit hue quotient) and the output register
// every stage carries a valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up during a stall
// an output stall holds m_axis_tdata and fills the pipe up to 12 pixels
// before s_axis_tready drops
// rst_n clears only the valid bits; payload registers are not reset
//
module rgb_to_hsl_pixel_core (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue [7:0], green [15:8], red [23:16]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue [7:0], saturation [15:8], lightness [23:16]
);
    import rgbhsl_pkg::*;

    logic [PIPE_DEPTH-1:0] adv;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    prep_t                 prep;
    quot_t                 quot;
    logic [CHAN_W-1:0]     hue_next;
    logic [CHAN_W-1:0]     sat_next;
    logic [3*CHAN_W-1:0]   tdata_next;
    logic [3*CHAN_W-1:0]   tdata_reg;

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        adv[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_axis_tready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    // first stage takes the input valid, later stages the one before them
    always_comb
    begin
        valid_next[0] = adv[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // operand stages
    rgbhsl_prep u_prep (
        .clk   (clk),
        .adv   (adv[PREP_STAGES-1:0]),
        .blue  (s_axis_tdata[CHAN_W-1:0]),
        .green (s_axis_tdata[2*CHAN_W-1:CHAN_W]),
        .red   (s_axis_tdata[3*CHAN_W-1:2*CHAN_W]),
        .prep  (prep)
    );

    // hue and saturation dividers side by side
    rgbhsl_div u_div (
        .clk  (clk),
        .adv  (adv[PREP_STAGES+QUO_W-1:PREP_STAGES]),
        .prep (prep),
        .quot (quot)
    );

    // output stage: gray pixels give zero hue and saturation, hue wraps
    // modulo 256, saturation is clamped at full scale
    always_comb
    begin
        if (quot.gray)
        begin
            hue_next = '0;
            sat_next = '0;
        end
        else
        begin
            hue_next = quot.hue_q[CHAN_W-1:0];
            if (quot.sat_q > QUO_W'(CHAN_MAX))
            begin
                sat_next = CHAN_W'(CHAN_MAX);
            end
            else
            begin
                sat_next = quot.sat_q[CHAN_W-1:0];
            end
        end
        tdata_next = {quot.light, sat_next, hue_next};
    end

    always_ff @(posedge clk)
    begin
        if (adv[PIPE_DEPTH-1])
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_axis_tdata  = tdata_reg;

endmodule

@@ rtl/core/rgbhsl_prep.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_prep
// two front stages: channel max/min and range/sum, then divider operands
// ----------------------------------------------------------------------------
module rgbhsl_prep (
    input  logic                            clk,
    input  logic [1:0]                      adv,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   blue,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   green,
    input  logic [rgbhsl_pkg::CHAN_W-1:0]   red,
    output rgbhsl_pkg::prep_t               prep
);
    import rgbhsl_pkg::*;

    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } sel_t;

    sel_t               sel_next;
    sel_t               sel_reg;
    logic [CHAN_W-1:0]  hi;
    logic [CHAN_W-1:0]  lo;
    logic [CHAN_W-1:0]  range_next;
    logic [CHAN_W-1:0]  range_reg;
    logic [CHAN_W:0]    sum_next;
    logic [CHAN_W:0]    sum_reg;
    logic signed [CHAN_W:0] diff_next;
    logic signed [CHAN_W:0] diff_reg;

    logic [HUE_DEN_W-1:0] k_range;
    logic [HUE_DEN_W-1:0] six_range;
    logic signed [HUE_DEN_W:0] d_full;
    logic [HUE_DEN_W-1:0] d_val;
    logic [CHAN_W+1:0]    other;
    logic [CHAN_W+1:0]    den_full;
    prep_t                prep_next;
    prep_t                prep_reg;

    // stage a: max, min and which channel holds the max (red, green, blue)
    always_comb
    begin
        if (red >= green && red >= blue)
        begin
            sel_next  = SEL_RED;
            hi        = red;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            sel_next  = SEL_GREEN;
            hi        = green;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sel_next  = SEL_BLUE;
            hi        = blue;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
        lo = red;
        if (green < lo)
        begin
            lo = green;
        end
        if (blue < lo)
        begin
            lo = blue;
        end
        range_next = hi - lo;
        sum_next   = {1'b0, hi} + {1'b0, lo};
    end

    // stage b: dividends and divisors
    always_comb
    begin
        six_range = (HUE_DEN_W'(range_reg) << 2) + (HUE_DEN_W'(range_reg) << 1);
        case (sel_reg)
            SEL_RED:   k_range = six_range;
            SEL_GREEN: k_range = HUE_DEN_W'(range_reg) << 1;
            SEL_BLUE:  k_range = HUE_DEN_W'(range_reg) << 2;
            default:   k_range = '0;
        endcase
        d_full = $signed({1'b0, k_range})
               + $signed({{(HUE_DEN_W-CHAN_W){diff_reg[CHAN_W]}}, diff_reg});
        d_val  = d_full[HUE_DEN_W-1:0];

        // 255 * x as (x << 8) - x
        prep_next.hue_num = {d_val, 8'b0} - HUE_NUM_W'(d_val);
        prep_next.hue_den = six_range;
        prep_next.sat_num = {range_reg, 8'b0} - SAT_NUM_W'(range_reg);

        other = (CHAN_W+2)'(SUM_TOP) - {1'b0, sum_reg};
        if ({1'b0, sum_reg} < other)
        begin
            den_full = {1'b0, sum_reg};
        end
        else
        begin
            den_full = other;
        end
        if (den_full == '0)
        begin
            den_full = (CHAN_W+2)'(1);
        end
        prep_next.sat_den = den_full[SAT_DEN_W-1:0];
        prep_next.gray    = (range_reg == '0);
        prep_next.light   = sum_reg[CHAN_W:1];
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sel_reg   <= sel_next;
            range_reg <= range_next;
            sum_reg   <= sum_next;
            diff_reg  <= diff_next;
        end
        if (adv[1])
        begin
            prep_reg <= prep_next;
        end
    end

    assign prep = prep_reg;

endmodule

@@ rtl/core/rgbhsl_div.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_div
// pipelined restoring divider pair, one quotient bit per stage
// ----------------------------------------------------------------------------
module rgbhsl_div (
    input  logic                          clk,
    input  logic [rgbhsl_pkg::QUO_W-1:0]  adv,
    input  rgbhsl_pkg::prep_t             prep,
    output rgbhsl_pkg::quot_t             quot
);
    import rgbhsl_pkg::*;

    typedef struct packed {
        logic [HUE_CW-1:0]    hue_rem;
        logic [HUE_DEN_W-1:0] hue_den;
        logic [QUO_W-1:0]     hue_q;
        logic [SAT_CW-1:0]    sat_rem;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [QUO_W-1:0]     sat_q;
        logic                 gray;
        logic [CHAN_W-1:0]    light;
    } div_stage_t;

    div_stage_t stage_in   [QUO_W];
    div_stage_t stage_next [QUO_W];
    div_stage_t stage_reg  [QUO_W];

    genvar k;
    generate
        for (k = 0; k < QUO_W; k++)
        begin : g_stage
            localparam int BIT = QUO_W - 1 - k;
            logic [HUE_CW-1:0] hue_sh;
            logic [SAT_CW-1:0] sat_sh;

            if (k == 0)
            begin : g_first
                always_comb
                begin
                    stage_in[k].hue_rem = HUE_CW'(prep.hue_num);
                    stage_in[k].hue_den = prep.hue_den;
                    stage_in[k].hue_q   = '0;
                    stage_in[k].sat_rem = SAT_CW'(prep.sat_num);
                    stage_in[k].sat_den = prep.sat_den;
                    stage_in[k].sat_q   = '0;
                    stage_in[k].gray    = prep.gray;
                    stage_in[k].light   = prep.light;
                end
            end
            else
            begin : g_next
                assign stage_in[k] = stage_reg[k-1];
            end

            // try subtracting the divisor aligned to this quotient bit
            always_comb
            begin
                hue_sh        = HUE_CW'(stage_in[k].hue_den) << BIT;
                sat_sh        = SAT_CW'(stage_in[k].sat_den) << BIT;
                stage_next[k] = stage_in[k];
                if (stage_in[k].hue_rem >= hue_sh)
                begin
                    stage_next[k].hue_rem    = stage_in[k].hue_rem - hue_sh;
                    stage_next[k].hue_q[BIT] = 1'b1;
                end
                if (stage_in[k].sat_rem >= sat_sh)
                begin
                    stage_next[k].sat_rem    = stage_in[k].sat_rem - sat_sh;
                    stage_next[k].sat_q[BIT] = 1'b1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k])
                begin
                    stage_reg[k] <= stage_next[k];
                end
            end
        end
    endgenerate

    assign quot.hue_q = stage_reg[QUO_W-1].hue_q;
    assign quot.sat_q = stage_reg[QUO_W-1].sat_q;
    assign quot.gray  = stage_reg[QUO_W-1].gray;
    assign quot.light = stage_reg[QUO_W-1].light;

endmodule

@@ rtl/core/rgbhsl_checker.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_checker
// port-level checks of the rgb to hsl pixel core, bound to the top level
// ----------------------------------------------------------------------------
module rgbhsl_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer changed while stalled");

    // an empty output register never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // a draining output lets the whole pipe move
    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

    // zero saturation only comes from a gray pixel, which has zero hue
    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[15:8] == 8'd0) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("nonzero hue with zero saturation");

endmodule

bind rgb_to_hsl_pixel_core rgbhsl_checker u_rgbhsl_checker (.*);
